// ===== design/rrts_pkg.sv =====
// Shared codes, state encoding and interface structs of the round-robin thread scheduler.
`default_nettype none

package rrts_pkg;

    localparam int OUT_ID_W = 3;

    // operation codes carried on the input tuser
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_ADD     = 3'd1;
    localparam logic [2:0] FUNC_SUSPEND = 3'd2;
    localparam logic [2:0] FUNC_SLEEP   = 3'd3;
    localparam logic [2:0] FUNC_KILL    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NO_AWAKE  = 2'd2;
    localparam logic [1:0] ST_NO_THREAD = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SW_NEXT,
        S_SCAN,
        S_DEC,
        S_DEC_LAST,
        S_ADD_ID,
        S_ADD_LNK,
        S_ADD_W2,
        S_ADD_W3,
        S_KILL_W1,
        S_KILL_W2,
        S_KILL_W3,
        S_DONE
    } t_state;

    // per-field write enables of the slot table row
    typedef struct packed {
        logic next;
        logic prev;
        logic free;
    } t_slot_we;

    typedef struct packed {
        logic                valid;
        logic [1:0]          status;
        logic [OUT_ID_W-1:0] running_id;
        logic [OUT_ID_W-1:0] added_id;
    } t_result;

endpackage

`default_nettype wire

// ===== design/rrts_slot_ram.sv =====
// Slot table: ring links and free-ID stack, one row per slot, one read and one write port.
`default_nettype none

module rrts_slot_ram #(
    parameter int DEPTH = 8,
    parameter int ID_W  = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_rd_en,
    input  wire  [ID_W-1:0]       i_rd_addr,
    output logic [ID_W-1:0]       o_rd_next,
    output logic [ID_W-1:0]       o_rd_prev,
    output logic [ID_W-1:0]       o_rd_free,
    input  rrts_pkg::t_slot_we    i_we,
    input  wire  [ID_W-1:0]       i_wr_addr,
    input  wire  [ID_W-1:0]       i_wr_next,
    input  wire  [ID_W-1:0]       i_wr_prev,
    input  wire  [ID_W-1:0]       i_wr_free
);
    import rrts_pkg::*;

    logic [ID_W-1:0]  r_next_mem [DEPTH];
    logic [ID_W-1:0]  r_prev_mem [DEPTH];
    logic [ID_W-1:0]  r_free_mem [DEPTH];
    // stack entry not yet written reads as its own index
    logic [DEPTH-1:0] r_free_vld;

    always_ff @(posedge i_clk) begin
        if (i_we.next) begin
            r_next_mem[i_wr_addr] <= i_wr_next;
        end
        if (i_we.prev) begin
            r_prev_mem[i_wr_addr] <= i_wr_prev;
        end
        if (i_we.free) begin
            r_free_mem[i_wr_addr] <= i_wr_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_vld <= '0;
        end else if (i_we.free) begin
            r_free_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_next <= r_next_mem[i_rd_addr];
            o_rd_prev <= r_prev_mem[i_rd_addr];
            o_rd_free <= r_free_vld[i_rd_addr] ? r_free_mem[i_rd_addr] : i_rd_addr;
        end
    end

endmodule

`default_nettype wire

// ===== design/rrts_sleep_ram.sv =====
// Sleep countdown memory, one 16-bit entry per slot, one read and one write port.
`default_nettype none

module rrts_sleep_ram #(
    parameter int DEPTH = 8,
    parameter int ID_W  = 3
) (
    input  wire               i_clk,
    input  wire               i_rd_en,
    input  wire  [ID_W-1:0]   i_rd_addr,
    output logic [15:0]       o_rd_data,
    input  wire               i_we,
    input  wire  [ID_W-1:0]   i_wr_addr,
    input  wire  [15:0]       i_wr_data
);
    // an entry is cleared when its slot joins the ring, before any scan reads it
    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/rrts_seq.sv =====
// Operation sequencer: ring scan, link updates, free stack and sleep decrement sweep.
`default_nettype none

module rrts_seq #(
    parameter int MAX_THREADS = 8,
    parameter int ID_W        = 3,
    parameter int CNT_W       = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [2:0]            i_func,
    input  wire  [15:0]           i_ticks,
    input  wire                   i_out_free,
    output logic                  o_idle,
    output rrts_pkg::t_result     o_result,
    // slot table
    output logic                  o_slot_rd_en,
    output logic [ID_W-1:0]       o_slot_rd_addr,
    input  wire  [ID_W-1:0]       i_slot_rd_next,
    input  wire  [ID_W-1:0]       i_slot_rd_prev,
    input  wire  [ID_W-1:0]       i_slot_rd_free,
    output rrts_pkg::t_slot_we    o_slot_we,
    output logic [ID_W-1:0]       o_slot_wr_addr,
    output logic [ID_W-1:0]       o_slot_wr_next,
    output logic [ID_W-1:0]       o_slot_wr_prev,
    output logic [ID_W-1:0]       o_slot_wr_free,
    // sleep memory
    output logic                  o_sleep_rd_en,
    output logic [ID_W-1:0]       o_sleep_rd_addr,
    input  wire  [15:0]           i_sleep_rd_data,
    output logic                  o_sleep_we,
    output logic [ID_W-1:0]       o_sleep_wr_addr,
    output logic [15:0]           o_sleep_wr_data
);
    import rrts_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_THREADS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [ID_W-1:0]  LAST_IDX = ID_W'(MAX_THREADS - 1);

    t_state            r_state, n_state;
    logic [2:0]        r_func, n_func;
    logic [15:0]       r_ticks, n_ticks;
    logic [ID_W-1:0]   r_running, n_running;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_cur, n_cur;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [ID_W-1:0]   r_fallback, n_fallback;
    logic [ID_W-1:0]   r_id, n_id;
    logic [ID_W-1:0]   r_after, n_after;
    logic [ID_W-1:0]   r_p, n_p;
    logic [ID_W-1:0]   r_k, n_k;
    logic [ID_W-1:0]   r_wa, n_wa;
    logic              r_dv, n_dv;
    logic [1:0]        r_status, n_status;
    logic [ID_W-1:0]   r_added, n_added;

    logic [CNT_W-1:0]  cnt_dec;
    logic [15:0]       sleep_dec;
    logic              scan_end;

    assign cnt_dec   = r_count - CNT_ONE;
    assign sleep_dec = (i_sleep_rd_data != 16'd0) ? i_sleep_rd_data - 16'd1 : i_sleep_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= '0;
            r_count   <= '0;
            r_dv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_count   <= n_count;
            r_dv      <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_ticks    <= n_ticks;
        r_cur      <= n_cur;
        r_i        <= n_i;
        r_fallback <= n_fallback;
        r_id       <= n_id;
        r_after    <= n_after;
        r_p        <= n_p;
        r_k        <= n_k;
        r_wa       <= n_wa;
        r_status   <= n_status;
        r_added    <= n_added;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_ticks    = r_ticks;
        n_running  = r_running;
        n_count    = r_count;
        n_cur      = r_cur;
        n_i        = r_i;
        n_fallback = r_fallback;
        n_id       = r_id;
        n_after    = r_after;
        n_p        = r_p;
        n_k        = r_k;
        n_wa       = r_wa;
        n_dv       = r_dv;
        n_status   = r_status;
        n_added    = r_added;
        scan_end   = 1'b0;

        o_idle          = 1'b0;
        o_slot_rd_en    = 1'b0;
        o_slot_rd_addr  = r_running;
        o_slot_we       = '0;
        o_slot_wr_addr  = r_running;
        o_slot_wr_next  = '0;
        o_slot_wr_prev  = '0;
        o_slot_wr_free  = '0;
        o_sleep_rd_en   = 1'b0;
        o_sleep_rd_addr = r_cur;
        o_sleep_we      = 1'b0;
        o_sleep_wr_addr = r_running;
        o_sleep_wr_data = '0;

        o_result.valid      = 1'b0;
        o_result.status     = r_status;
        o_result.running_id = (r_count == '0) ? '0 : OUT_ID_W'(r_running);
        o_result.added_id   = OUT_ID_W'(r_added);

        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_func   = i_func;
                    n_ticks  = i_ticks;
                    n_status = ST_OK;
                    n_added  = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_func)
                    FUNC_TICK: begin
                        if (r_count == '0) begin
                            n_status = ST_NO_THREAD;
                            n_k      = '0;
                            n_dv     = 1'b0;
                            n_state  = S_DEC;
                        end else begin
                            o_slot_rd_en = 1'b1;
                            n_fallback   = r_running;
                            n_state      = S_SW_NEXT;
                        end
                    end
                    FUNC_ADD: begin
                        if (r_count == CNT_MAX) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            o_slot_rd_en   = 1'b1;
                            o_slot_rd_addr = r_count[ID_W-1:0];
                            n_state        = S_ADD_ID;
                        end
                    end
                    FUNC_SUSPEND, FUNC_SLEEP: begin
                        if (r_count == '0) begin
                            n_status = ST_NO_THREAD;
                            n_state  = S_DONE;
                        end else begin
                            o_slot_rd_en = 1'b1;
                            n_fallback   = r_running;
                            if (r_func == FUNC_SLEEP) begin
                                o_sleep_we      = 1'b1;
                                o_sleep_wr_data = r_ticks;
                            end
                            n_state = S_SW_NEXT;
                        end
                    end
                    FUNC_KILL: begin
                        if (r_count == '0) begin
                            n_status = ST_NO_THREAD;
                            n_state  = S_DONE;
                        end else begin
                            o_slot_rd_en = 1'b1;
                            n_state      = S_KILL_W1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SW_NEXT: begin
                // scan starts at the running slot's successor
                o_slot_rd_en    = 1'b1;
                o_slot_rd_addr  = i_slot_rd_next;
                o_sleep_rd_en   = 1'b1;
                o_sleep_rd_addr = i_slot_rd_next;
                n_cur           = i_slot_rd_next;
                n_i             = '0;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                // data of r_cur is on the read ports; one ring member per cycle
                if (i_sleep_rd_data == 16'd0) begin
                    n_running = r_cur;
                    n_status  = ST_OK;
                    scan_end  = 1'b1;
                end else if ((r_i + CNT_ONE) == r_count) begin
                    n_running = r_fallback;
                    n_status  = ST_NO_AWAKE;
                    scan_end  = 1'b1;
                end else begin
                    o_slot_rd_en    = 1'b1;
                    o_slot_rd_addr  = i_slot_rd_next;
                    o_sleep_rd_en   = 1'b1;
                    o_sleep_rd_addr = i_slot_rd_next;
                    n_cur           = i_slot_rd_next;
                    n_i             = r_i + CNT_ONE;
                end
                if (scan_end) begin
                    if (r_func == FUNC_TICK) begin
                        n_k     = '0;
                        n_dv    = 1'b0;
                        n_state = S_DEC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DEC: begin
                // read entry r_k while writing back the previous one
                o_sleep_rd_en   = 1'b1;
                o_sleep_rd_addr = r_k;
                o_sleep_we      = r_dv;
                o_sleep_wr_addr = r_wa;
                o_sleep_wr_data = sleep_dec;
                n_wa            = r_k;
                n_dv            = 1'b1;
                n_k             = r_k + ID_W'(1);
                if (r_k == LAST_IDX) begin
                    n_state = S_DEC_LAST;
                end
            end
            S_DEC_LAST: begin
                o_sleep_we      = 1'b1;
                o_sleep_wr_addr = r_wa;
                o_sleep_wr_data = sleep_dec;
                n_dv            = 1'b0;
                n_state         = S_DONE;
            end
            S_ADD_ID: begin
                n_id         = i_slot_rd_free;
                o_slot_rd_en = 1'b1;
                n_state      = S_ADD_LNK;
            end
            S_ADD_LNK: begin
                if (r_count == '0) begin
                    // ring of one
                    o_slot_we.next  = 1'b1;
                    o_slot_we.prev  = 1'b1;
                    o_slot_wr_addr  = r_id;
                    o_slot_wr_next  = r_id;
                    o_slot_wr_prev  = r_id;
                    o_sleep_we      = 1'b1;
                    o_sleep_wr_addr = r_id;
                    n_running       = r_id;
                    n_count         = r_count + CNT_ONE;
                    n_added         = r_id;
                    n_state         = S_DONE;
                end else begin
                    o_slot_we.next = 1'b1;
                    o_slot_wr_addr = r_running;
                    o_slot_wr_next = r_id;
                    n_after        = i_slot_rd_next;
                    n_state        = S_ADD_W2;
                end
            end
            S_ADD_W2: begin
                o_slot_we.prev = 1'b1;
                o_slot_wr_addr = r_after;
                o_slot_wr_prev = r_id;
                n_state        = S_ADD_W3;
            end
            S_ADD_W3: begin
                o_slot_we.next  = 1'b1;
                o_slot_we.prev  = 1'b1;
                o_slot_wr_addr  = r_id;
                o_slot_wr_next  = r_after;
                o_slot_wr_prev  = r_running;
                o_sleep_we      = 1'b1;
                o_sleep_wr_addr = r_id;
                n_count         = r_count + CNT_ONE;
                n_added         = r_id;
                n_state         = S_DONE;
            end
            S_KILL_W1: begin
                o_slot_we.next = 1'b1;
                o_slot_wr_addr = i_slot_rd_prev;
                o_slot_wr_next = i_slot_rd_next;
                n_p            = i_slot_rd_prev;
                n_after        = i_slot_rd_next;
                n_state        = S_KILL_W2;
            end
            S_KILL_W2: begin
                o_slot_we.prev = 1'b1;
                o_slot_wr_addr = r_after;
                o_slot_wr_prev = r_p;
                n_state        = S_KILL_W3;
            end
            S_KILL_W3: begin
                // push the dead slot and continue the scan at its successor
                o_slot_we.free = 1'b1;
                o_slot_wr_addr = cnt_dec[ID_W-1:0];
                o_slot_wr_free = r_running;
                n_count        = cnt_dec;
                if (r_count == CNT_ONE) begin
                    n_running = '0;
                    n_state   = S_DONE;
                end else begin
                    o_slot_rd_en    = 1'b1;
                    o_slot_rd_addr  = r_after;
                    o_sleep_rd_en   = 1'b1;
                    o_sleep_rd_addr = r_after;
                    n_cur           = r_after;
                    n_i             = '0;
                    n_fallback      = r_after;
                    n_state         = S_SCAN;
                end
            end
            S_DONE: begin
                o_result.valid = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/round_robin_thread_scheduler.sv =====
// Round-robin thread scheduler with per-slot sleep timers, top level.
// One item at a time; the result is loaded into an output register from the done state once that register is free.
// The ring scan visits one ring member per cycle; a kill of the last thread skips it.
// A tick also runs a decrement sweep over all MAX_THREADS sleep entries, even with no thread.
// Synchronous reset clears the control state; no memory clearing pass.
`default_nettype none

module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] sleep_ticks
    input  wire  [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] status, [4:2] running_id, [7:5] added_id
);
    import rrts_pkg::*;

    localparam int ID_W  = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    logic              idle;
    logic              out_free;
    t_result           result;

    logic              slot_rd_en;
    logic [ID_W-1:0]   slot_rd_addr;
    logic [ID_W-1:0]   slot_rd_next;
    logic [ID_W-1:0]   slot_rd_prev;
    logic [ID_W-1:0]   slot_rd_free;
    t_slot_we          slot_we;
    logic [ID_W-1:0]   slot_wr_addr;
    logic [ID_W-1:0]   slot_wr_next;
    logic [ID_W-1:0]   slot_wr_prev;
    logic [ID_W-1:0]   slot_wr_free;

    logic              sleep_rd_en;
    logic [ID_W-1:0]   sleep_rd_addr;
    logic [15:0]       sleep_rd_data;
    logic              sleep_we;
    logic [ID_W-1:0]   sleep_wr_addr;
    logic [15:0]       sleep_wr_data;

    logic              r_m_valid;
    logic [7:0]        r_m_data;

    assign s_axis_tready = idle;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // output register: the sequencer may take a new item while this one waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (result.valid && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid && out_free) begin
            r_m_data <= {result.added_id, result.running_id, result.status};
        end
    end

    rrts_seq #(
        .MAX_THREADS (MAX_THREADS),
        .ID_W        (ID_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (s_axis_tvalid),
        .i_func          (s_axis_tuser),
        .i_ticks         (s_axis_tdata),
        .i_out_free      (out_free),
        .o_idle          (idle),
        .o_result        (result),
        .o_slot_rd_en    (slot_rd_en),
        .o_slot_rd_addr  (slot_rd_addr),
        .i_slot_rd_next  (slot_rd_next),
        .i_slot_rd_prev  (slot_rd_prev),
        .i_slot_rd_free  (slot_rd_free),
        .o_slot_we       (slot_we),
        .o_slot_wr_addr  (slot_wr_addr),
        .o_slot_wr_next  (slot_wr_next),
        .o_slot_wr_prev  (slot_wr_prev),
        .o_slot_wr_free  (slot_wr_free),
        .o_sleep_rd_en   (sleep_rd_en),
        .o_sleep_rd_addr (sleep_rd_addr),
        .i_sleep_rd_data (sleep_rd_data),
        .o_sleep_we      (sleep_we),
        .o_sleep_wr_addr (sleep_wr_addr),
        .o_sleep_wr_data (sleep_wr_data)
    );

    rrts_slot_ram #(
        .DEPTH (MAX_THREADS),
        .ID_W  (ID_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_next (slot_rd_next),
        .o_rd_prev (slot_rd_prev),
        .o_rd_free (slot_rd_free),
        .i_we      (slot_we),
        .i_wr_addr (slot_wr_addr),
        .i_wr_next (slot_wr_next),
        .i_wr_prev (slot_wr_prev),
        .i_wr_free (slot_wr_free)
    );

    rrts_sleep_ram #(
        .DEPTH (MAX_THREADS),
        .ID_W  (ID_W)
    ) u_sleep_ram (
        .i_clk     (i_clk),
        .i_rd_en   (sleep_rd_en),
        .i_rd_addr (sleep_rd_addr),
        .o_rd_data (sleep_rd_data),
        .i_we      (sleep_we),
        .i_wr_addr (sleep_wr_addr),
        .i_wr_data (sleep_wr_data)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the round-robin thread scheduler.
`timescale 1ns / 100ps

module testbench;
    import rrts_pkg::*;

    localparam int SLOTS          = 8;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // func codes the block ignores
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    // same bit order as m_axis_tdata
    typedef struct packed {
        logic [2:0] added_id;
        logic [2:0] running_id;
        logic [1:0] status;
    } t_sched_report;

    class sched_scoreboard;
        logic [2:0]    next_lnk [SLOTS];
        logic [2:0]    prev_lnk [SLOTS];
        logic [2:0]    free_ids [SLOTS];
        logic [15:0]   nap      [SLOTS];
        int            free_top;
        int            live;
        logic [2:0]    cur;
        t_sched_report due_reports[$];
        int            failures;

        function new();
            foreach (free_ids[i]) begin
                free_ids[i] = i[2:0];
                nap[i]      = '0;
                next_lnk[i] = '0;
                prev_lnk[i] = '0;
            end
            free_top = 0;
            live     = 0;
            cur      = '0;
            failures = 0;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function int threads();
            return live;
        endfunction

        // walk n ring members from start, first one with no sleep left
        function int first_awake(logic [2:0] start, int n);
            logic [2:0] s;
            s = start;
            for (int i = 0; i < n; i++) begin
                if (nap[s] == 16'd0)
                    return int'(s);
                s = next_lnk[s];
            end
            return -1;
        endfunction

        function logic [1:0] switch_away();
            int pick;
            pick = first_awake(next_lnk[cur], live);
            if (pick < 0)
                return ST_NO_AWAKE;
            cur = pick[2:0];
            return ST_OK;
        endfunction

        function void note_command(logic [2:0] func, logic [15:0] ticks);
            t_sched_report r;
            int            pick;
            logic [2:0]    id;
            logic [2:0]    after;
            logic [2:0]    p;
            logic [2:0]    n;
            r = '0;
            case (func)
                FUNC_TICK: begin
                    if (live == 0)
                        r.status = ST_NO_THREAD;
                    else
                        r.status = switch_away();
                    foreach (nap[i])
                        if (nap[i] != 16'd0)
                            nap[i]--;
                end
                FUNC_ADD: begin
                    if (live >= SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        id = free_ids[free_top];
                        free_top++;
                        if (live == 0) begin
                            next_lnk[id] = id;
                            prev_lnk[id] = id;
                            cur          = id;
                        end else begin
                            after           = next_lnk[cur];
                            next_lnk[cur]   = id;
                            prev_lnk[after] = id;
                            prev_lnk[id]    = cur;
                            next_lnk[id]    = after;
                        end
                        live++;
                        nap[id]    = '0;
                        r.added_id = id;
                    end
                end
                FUNC_SUSPEND, FUNC_SLEEP: begin
                    if (live == 0) begin
                        r.status = ST_NO_THREAD;
                    end else begin
                        if (func == FUNC_SLEEP)
                            nap[cur] = ticks;
                        r.status = switch_away();
                    end
                end
                FUNC_KILL: begin
                    if (live == 0) begin
                        r.status = ST_NO_THREAD;
                    end else begin
                        p           = prev_lnk[cur];
                        n           = next_lnk[cur];
                        next_lnk[p] = n;
                        prev_lnk[n] = p;
                        free_top--;
                        free_ids[free_top] = cur;
                        live--;
                        if (live == 0) begin
                            cur = '0;
                        end else begin
                            // nobody awake: successor of the killed slot runs anyway
                            pick = first_awake(n, live);
                            if (pick < 0) begin
                                cur      = n;
                                r.status = ST_NO_AWAKE;
                            end else begin
                                cur = pick[2:0];
                            end
                        end
                    end
                end
                default: ;
            endcase
            r.running_id = (live == 0) ? 3'd0 : cur;
            due_reports.push_back(r);
        endfunction

        function void check_report(logic [7:0] data);
            t_sched_report got;
            t_sched_report want;
            got = data;
            if (due_reports.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result %h at %0t", data, $realtime);
                return;
            end
            want = due_reports.pop_front();
            if (got.status != want.status || got.running_id != want.running_id ||
                    got.added_id != want.added_id) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch at %0t: status %0d/%0d running %0d/%0d added %0d/%0d",
                             $realtime, want.status, got.status, want.running_id,
                             got.running_id, want.added_id, got.added_id);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sleep_ticks
    logic [2:0]  s_axis_tuser;   // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [1:0] status, [4:2] running_id, [7:5] added_id

    sched_scoreboard sb = new();
    bit              tx_quiet;

    round_robin_thread_scheduler #(.MAX_THREADS(SLOTS)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input logic [2:0] func, input logic [15:0] ticks);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= ticks;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_command(func, ticks);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_func(int live);
        int roll;
        int add_w;
        int kill_w;
        roll   = $urandom_range(0, 99);
        add_w  = (live < 3) ? 35 : ((live >= SLOTS) ? 8 : 18);
        kill_w = (live >= 6) ? 25 : 12;
        if (roll < 5)
            return 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        if (roll < 5 + add_w)
            return FUNC_ADD;
        if (roll < 5 + add_w + kill_w)
            return FUNC_KILL;
        if (roll < 25 + add_w + kill_w)
            return FUNC_SLEEP;
        if (roll < 35 + add_w + kill_w)
            return FUNC_SUSPEND;
        return FUNC_TICK;
    endfunction

    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(0, 16'hFFFF));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2, 3:    return 16'($urandom_range(0, 40));
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    // result side
    initial begin
        int gap;
        int results;
        results = 0;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = (((results / 120) % 4) == 3) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_report(m_axis_tdata);
            results++;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin
        int         done;
        bit         paused;
        logic [2:0] func;
        logic [15:0] ticks;
        done     = 0;
        paused   = 0;
        tx_quiet = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, then spare codes
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_SUSPEND, 16'h0000);
        send_item(FUNC_SLEEP, 16'hFFFF);
        send_item(FUNC_KILL, 16'h0000);
        send_item(FUNC_SPARE_LO, 16'hFFFF);
        send_item(FUNC_SPARE_HI, 16'h0000);
        // three threads, all put to sleep
        repeat (3) send_item(FUNC_ADD, 16'h0000);
        send_item(FUNC_SLEEP, 16'hFFFF);
        send_item(FUNC_SLEEP, 16'h0002);
        send_item(FUNC_SLEEP, 16'h0003);
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_KILL, 16'h0000);
        send_item(FUNC_TICK, 16'h0000);
        // fill the table, then overflow
        repeat (6) send_item(FUNC_ADD, 16'h0000);
        send_item(FUNC_ADD, 16'h0000);
        send_item(FUNC_SUSPEND, 16'h0000);
        send_item(FUNC_SLEEP, 16'h0000);
        hold_until_drained();

        while (done < RANDOM_ITEMS) begin
            if (done == RANDOM_ITEMS / 2 && !paused) begin
                hold_until_drained();
                paused = 1;
            end
            tx_quiet = ((done / 150) % 3) == 2;
            func  = pick_func(sb.threads());
            ticks = (func == FUNC_SLEEP) ? pick_ticks() : 16'($urandom);
            send_item(func, ticks);
            if (func <= FUNC_KILL)
                done++;
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
